[hdl/tbp_pkg.sv]
`timescale 1ns / 1ps
package tbp_pkg;

  localparam int HIST_W      = 14;
  localparam int HIST_LEN_W  = 4;
  localparam int WORD_W      = 30;
  localparam int PC_W        = 32;
  localparam int CNT_W       = 32;
  localparam int CTR_W       = 3;
  localparam int CHO_W       = 2;
  localparam int IN_DATA_W   = 40;
  localparam int OUT_DATA_W  = 72;
  localparam int Q_DEPTH     = 3;
  localparam int Q_PTR_W     = 2;
  localparam int Q_CNT_W     = 2;

  localparam logic [HIST_LEN_W-1:0] HIST_LEN_RESET = 4'd8;
  localparam logic [HIST_LEN_W-1:0] HIST_LEN_MAX   = 4'd14;
  localparam logic [CTR_W-1:0]      CTR_RESET      = 3'd4;
  localparam logic [CTR_W-1:0]      CTR_TOP        = 3'd7;
  localparam logic [CHO_W-1:0]      CHO_RESET      = 2'd1;
  localparam logic [CHO_W-1:0]      CHO_TOP        = 2'd3;

  typedef struct packed {
    logic             predicted_taken;
    logic             mispredicted;
    logic             chose_gshare;
    logic [CNT_W-1:0] prediction_total;
    logic [CNT_W-1:0] misprediction_total;
  } tbp_result_t;

  function automatic logic [CTR_W-1:0] train3(logic [CTR_W-1:0] c, logic up);
    logic [CTR_W-1:0] r;
    r = c;
    if (up) begin
      if (c != CTR_TOP) r = c + CTR_W'(1);
    end else begin
      if (c != '0) r = c - CTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [HIST_W-1:0] hist_mask(logic [HIST_LEN_W-1:0] len);
    logic [HIST_W:0] one_hot;
    one_hot = (HIST_W+1)'(1) << len;
    return HIST_W'(one_hot - (HIST_W+1)'(1));
  endfunction

endpackage

[hdl/tournament_branch_predictor_top.sv]
`timescale 1ns / 1ps
// Tournament branch predictor (gshare + bimodal with a chooser table).
// in_*  : one resolved branch per beat, tdata = {taken, branch_pc}.
// out_* : one result beat per input beat, in order.
// cfg_* : writes history_length (4 bits, 15 reads as 14); write only when idle.
// An accepted beat is registered into the update stage (table read); its result
// is then pushed into the output queue, which drives out_tvalid. Throughput: one
// branch per cycle while in_tready is high. Each table is a 1R1W SRAM with
// registered read; the read-modify-write of back-to-back branches to the same
// entry is covered by a one-entry write-forwarding register per table.
// Reset: rst_n (synchronous, active low) clears history, totals and the output
// queue, then a sweep writes every table entry to its initial value
// (gshare/bimodal 4, chooser 1). The sweep covers 2^max(GSHARE_INDEX_BITS,
// BIMODAL_INDEX_BITS, CHOOSER_INDEX_BITS) addresses (16384 by default);
// in_tready stays low until it ends. cfg writes are taken during the sweep.
// Stall: results collect in a three-beat output queue; in_tready drops only
// when the queue plus the beat in flight already fill it, so no result is lost.
module tournament_branch_predictor_top import tbp_pkg::*; #(
  parameter int GSHARE_INDEX_BITS  = 14,
  parameter int BIMODAL_INDEX_BITS = 12,
  parameter int CHOOSER_INDEX_BITS = 10
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [31:0] branch_pc, [32] taken, [39:33] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] predicted_taken, [1] mispredicted, [2] chose_gshare,
  // [34:3] prediction_total, [66:35] misprediction_total, [71:67] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [HIST_LEN_W-1:0] cfg_data
);

  localparam int GB = GSHARE_INDEX_BITS;
  localparam int BB = BIMODAL_INDEX_BITS;
  localparam int CB = CHOOSER_INDEX_BITS;
  localparam int SW_GB = (GB > BB) ? GB : BB;
  localparam int SW = (SW_GB > CB) ? SW_GB : CB;

  logic                  sweep_r;
  logic [SW-1:0]         sweep_cnt_r;
  logic [HIST_LEN_W-1:0] hist_len_r;
  logic [HIST_W-1:0]     hist_r, hist_nxt;
  logic [CNT_W-1:0]      pred_total_r, miss_total_r, pred_total_nxt, miss_total_nxt;

  logic                  in_acc;
  logic [WORD_W-1:0]     word;
  logic [WORD_W-1:0]     gx;
  logic [GB-1:0]         gi;
  logic [BB-1:0]         bi;
  logic [CB-1:0]         ci;
  logic                  in_taken;

  logic                  s1_valid_r;
  logic [GB-1:0]         s1_gi_r;
  logic [BB-1:0]         s1_bi_r;
  logic [CB-1:0]         s1_ci_r;
  logic                  s1_taken_r;

  logic                  fw_valid_r;
  logic [GB-1:0]         fw_g_addr_r;
  logic [BB-1:0]         fw_b_addr_r;
  logic [CB-1:0]         fw_c_addr_r;
  logic [CTR_W-1:0]      fw_g_data_r, fw_b_data_r;
  logic [CHO_W-1:0]      fw_c_data_r;

  logic [CTR_W-1:0]      g_rdata, b_rdata, g_cnt, b_cnt, g_new, b_new;
  logic [CHO_W-1:0]      c_rdata, c_cnt, c_new;
  logic                  g_pred, b_pred, use_g, sel_pred, miss, g_ok, b_ok;

  logic                  g_we, b_we, c_we;
  logic [GB-1:0]         g_waddr;
  logic [BB-1:0]         b_waddr;
  logic [CB-1:0]         c_waddr;
  logic [CTR_W-1:0]      g_wdata, b_wdata;
  logic [CHO_W-1:0]      c_wdata;

  tbp_result_t           res;
  tbp_result_t           q_data;
  logic [Q_CNT_W-1:0]    q_count;

  // ---- accept stage ----
  assign in_tready = !sweep_r &&
                     ((Q_CNT_W+1)'(q_count) + (Q_CNT_W+1)'(s1_valid_r)
                      < (Q_CNT_W+1)'(Q_DEPTH));
  assign in_acc    = in_tvalid & in_tready;
  assign in_taken  = in_tdata[PC_W];
  assign word      = in_tdata[PC_W-1:2];
  assign gx        = word ^ WORD_W'(hist_r & hist_mask(hist_len_r));
  assign gi        = gx[GB-1:0];
  assign bi        = word[BB-1:0];
  assign ci        = word[CB-1:0];

  always_comb begin
    hist_nxt = hist_r;
    if (hist_len_r != '0) begin
      hist_nxt = (hist_r >> 1) |
                 (HIST_W'(in_taken) << (hist_len_r - HIST_LEN_W'(1)));
    end
  end

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sweep_r     <= 1'b1;
      sweep_cnt_r <= '0;
      hist_len_r  <= HIST_LEN_RESET;
      hist_r      <= '0;
      s1_valid_r  <= 1'b0;
      fw_valid_r  <= 1'b0;
      pred_total_r <= '0;
      miss_total_r <= '0;
    end else begin
      if (sweep_r) begin
        sweep_cnt_r <= sweep_cnt_r + SW'(1);
        if (sweep_cnt_r == '1) sweep_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        hist_len_r <= (cfg_data > HIST_LEN_MAX) ? HIST_LEN_MAX : cfg_data;
      end
      if (in_acc) hist_r <= hist_nxt;
      s1_valid_r <= in_acc;
      if (s1_valid_r) begin
        fw_valid_r   <= 1'b1;
        pred_total_r <= pred_total_nxt;
        miss_total_r <= miss_total_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_gi_r    <= gi;
      s1_bi_r    <= bi;
      s1_ci_r    <= ci;
      s1_taken_r <= in_taken;
    end
    if (s1_valid_r) begin
      fw_g_addr_r <= s1_gi_r;
      fw_b_addr_r <= s1_bi_r;
      fw_c_addr_r <= s1_ci_r;
      fw_g_data_r <= g_new;
      fw_b_data_r <= b_new;
      fw_c_data_r <= c_new;
    end
  end

  // ---- update stage: read data plus forwarding ----
  assign g_cnt = (fw_valid_r && fw_g_addr_r == s1_gi_r) ? fw_g_data_r : g_rdata;
  assign b_cnt = (fw_valid_r && fw_b_addr_r == s1_bi_r) ? fw_b_data_r : b_rdata;
  assign c_cnt = (fw_valid_r && fw_c_addr_r == s1_ci_r) ? fw_c_data_r : c_rdata;

  assign g_pred     = (g_cnt >= CTR_RESET);
  assign b_pred     = (b_cnt >= CTR_RESET);
  assign use_g      = c_cnt[CHO_W-1];
  assign sel_pred   = use_g ? g_pred : b_pred;
  assign miss       = sel_pred ^ s1_taken_r;
  assign g_ok       = (g_pred == s1_taken_r);
  assign b_ok       = (b_pred == s1_taken_r);

  assign g_new = use_g ? train3(g_cnt, s1_taken_r) : g_cnt;
  assign b_new = use_g ? b_cnt : train3(b_cnt, s1_taken_r);

  always_comb begin
    c_new = c_cnt;
    if (g_ok && !b_ok && c_cnt != CHO_TOP) c_new = c_cnt + CHO_W'(1);
    else if (!g_ok && b_ok && c_cnt != '0) c_new = c_cnt - CHO_W'(1);
  end

  assign pred_total_nxt = pred_total_r + CNT_W'(1);
  assign miss_total_nxt = miss_total_r + CNT_W'(miss);

  // ---- table ports: sweep or write-back ----
  assign g_we    = sweep_r | s1_valid_r;
  assign b_we    = sweep_r | s1_valid_r;
  assign c_we    = sweep_r | s1_valid_r;
  assign g_waddr = sweep_r ? sweep_cnt_r[GB-1:0] : s1_gi_r;
  assign b_waddr = sweep_r ? sweep_cnt_r[BB-1:0] : s1_bi_r;
  assign c_waddr = sweep_r ? sweep_cnt_r[CB-1:0] : s1_ci_r;
  assign g_wdata = sweep_r ? CTR_RESET : g_new;
  assign b_wdata = sweep_r ? CTR_RESET : b_new;
  assign c_wdata = sweep_r ? CHO_RESET : c_new;

  tbp_ram #(.WIDTH(CTR_W), .ADDR_BITS(GB)) u_gshare_ram (
    .clk(clk), .we(g_we), .waddr(g_waddr), .wdata(g_wdata),
    .re(in_acc), .raddr(gi), .rdata(g_rdata)
  );

  tbp_ram #(.WIDTH(CTR_W), .ADDR_BITS(BB)) u_bimodal_ram (
    .clk(clk), .we(b_we), .waddr(b_waddr), .wdata(b_wdata),
    .re(in_acc), .raddr(bi), .rdata(b_rdata)
  );

  tbp_ram #(.WIDTH(CHO_W), .ADDR_BITS(CB)) u_chooser_ram (
    .clk(clk), .we(c_we), .waddr(c_waddr), .wdata(c_wdata),
    .re(in_acc), .raddr(ci), .rdata(c_rdata)
  );

  // ---- result queue ----
  always_comb begin
    res.predicted_taken     = sel_pred;
    res.mispredicted        = miss;
    res.chose_gshare        = use_g;
    res.prediction_total    = pred_total_nxt;
    res.misprediction_total = miss_total_nxt;
  end

  tbp_outq u_outq (
    .clk(clk), .rst_n(rst_n),
    .push(s1_valid_r), .push_data(res),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .out_data(q_data), .count(q_count)
  );

  assign out_tdata = {5'd0, q_data.misprediction_total, q_data.prediction_total,
                      q_data.chose_gshare, q_data.mispredicted,
                      q_data.predicted_taken};

`ifndef SYNTH
  a_no_accept_in_sweep: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |-> !sweep_r)
    else $error("input beat accepted during table sweep");

  a_queue_room: assert property (@(posedge clk) disable iff (!rst_n)
    ((Q_CNT_W+1)'(q_count) + (Q_CNT_W+1)'(s1_valid_r)) <= (Q_CNT_W+1)'(Q_DEPTH))
    else $error("result queue overflow");

  a_total_step: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r |=> (pred_total_r == $past(pred_total_r) + CNT_W'(1)))
    else $error("prediction total not advanced");

  a_s1_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> s1_valid_r)
    else $error("accepted beat did not reach update stage");
`endif

endmodule

[hdl/tbp_ram.sv]
`timescale 1ns / 1ps
module tbp_ram #(
  parameter int WIDTH     = 3,
  parameter int ADDR_BITS = 10
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [ADDR_BITS-1:0] waddr,
  input  logic [WIDTH-1:0]     wdata,
  input  logic                 re,
  input  logic [ADDR_BITS-1:0] raddr,
  output logic [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [1 << ADDR_BITS];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

[hdl/tbp_outq.sv]
`timescale 1ns / 1ps
module tbp_outq import tbp_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  tbp_result_t        push_data,
  output logic               out_valid,
  input  logic               out_ready,
  output tbp_result_t        out_data,
  output logic [Q_CNT_W-1:0] count
);

  tbp_result_t        entries_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [Q_CNT_W-1:0] count_r, count_nxt;
  logic               pop;

  function automatic logic [Q_PTR_W-1:0] ptr_inc(logic [Q_PTR_W-1:0] p);
    return (p == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : p + Q_PTR_W'(1);
  endfunction

  assign pop = out_valid & out_ready;

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) count_nxt = count_r + Q_CNT_W'(1);
    else if (!push && pop) count_nxt = count_r - Q_CNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= ptr_inc(wr_ptr_r);
      if (pop) rd_ptr_r <= ptr_inc(rd_ptr_r);
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wr_ptr_r] <= push_data;
  end

  assign out_valid = (count_r != '0);
  assign out_data  = entries_r[rd_ptr_r];
  assign count     = count_r;

endmodule
